/* rtl/bba_pkg.sv */
package bba_pkg;

   // Map size and field widths.
   localparam int N_BLOCKS = 1024;
   localparam int TYPE_W   = 1;
   localparam int START_W  = 10;
   localparam int LEN_W    = 11;
   localparam int STAT_W   = 2;
   localparam int OUT_W    = 10;

   // The map is stored as words; there are always at least two of them.
   localparam int WORD_W  = (N_BLOCKS >= 64) ? 32 : N_BLOCKS / 2;
   localparam int N_WORDS = N_BLOCKS / WORD_W;
   localparam int BLK_W   = $clog2(N_BLOCKS);
   localparam int WI_W    = $clog2(WORD_W);
   localparam int WA_W    = BLK_W - WI_W;

   // A run length seen inside one word, and bounds arithmetic on block indexes.
   localparam int RUN_W = LEN_W + 1;
   localparam int SUM_W = ((BLK_W > LEN_W) ? BLK_W : LEN_W) + 2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_BAD_LEN  = 2'd1,
      STAT_NO_RUN   = 2'd2,
      STAT_PAST_END = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SEEK,
      S_MARK,
      S_DONE
   } state_type;

endpackage

/* rtl/bba_if.sv */
interface bba_req_if import bba_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TYPE_W-1:0]    req_type;
   logic [START_W-1:0]   start_block;
   logic [LEN_W-1:0]     run_length;

   modport source (output valid, req_type, start_block, run_length, input ready);
   modport sink   (input valid, req_type, start_block, run_length, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [OUT_W-1:0]     run_start;

   modport source (output valid, status, run_start, input ready);
   modport sink   (input valid, status, run_start, output ready);
endinterface

/* rtl/bitmap_block_allocator.sv */
// Channel    Direction  Handshake      Payload
// req_port   in         valid/ready    req_type, start_block, run_length
// rsp_port   out        valid/ready    status, run_start
//
// An allocate item runs a first-fit scan that reads 1 to 32 map words, then marks the words
// its run touches; an allocate with no fitting run scans all 32 words, a free item only
// marks its words, and a failed check goes straight to the result.
// The map memory has a single read port, one 32-bit word per cycle.
// Reset is synchronous and marks every map word as unwritten, which reads as all free.
// One item is worked on at a time; its result waits in the output register while the next
// item is accepted, in the cycle after the load at the earliest, and worked on.

module bitmap_block_allocator import bba_pkg::*; (
   input logic        clock,
   input logic        reset,
   bba_req_if.sink    req_port,
   bba_rsp_if.source  rsp_port
);

   // Control and item registers.
   state_type            state_ff, state_in;
   logic [TYPE_W-1:0]    op_ff, op_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic [WA_W-1:0]      addr_ff, addr_in;
   logic [BLK_W-1:0]     first_ff, first_in;
   logic [BLK_W-1:0]     last_ff, last_in;
   status_type           status_ff, status_in;
   logic [OUT_W-1:0]     found_ff, found_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [OUT_W-1:0]     rsp_start_ff, rsp_start_in;

   // Map memory. A word never written since reset reads as all free.
   logic [WORD_W-1:0]    free_mem [N_WORDS];
   logic [N_WORDS-1:0]   row_valid_ff;
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 rd_valid_ff;
   logic [WA_W-1:0]      rd_addr;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_data;
   logic [WORD_W-1:0]    word;

   logic                 req_accept;
   logic                 load_rsp;
   logic [SUM_W-1:0]     req_end;

   // Scan datapath.
   logic [RUN_W-1:0]     run [WORD_W];
   logic [WORD_W-1:0]    hit;
   logic                 hit_any;
   logic [WI_W-1:0]      hit_idx;
   logic [BLK_W-1:0]     hit_blk;
   logic [BLK_W-1:0]     found_blk;

   // Mark datapath.
   logic [WA_W-1:0]      first_word;
   logic [WA_W-1:0]      last_word;
   logic [WI_W-1:0]      lo_off;
   logic [WI_W-1:0]      hi_off;
   logic [WORD_W-1:0]    mark_mask;

   assign req_accept = req_port.valid && req_port.ready;
   assign req_port.ready = (state_ff == S_IDLE);
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_port.ready);

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.status    = rsp_status_ff;
   assign rsp_port.run_start = rsp_start_ff;

   assign req_end = SUM_W'(req_port.start_block) + SUM_W'(req_port.run_length);

   assign word = rd_valid_ff ? rd_data_ff : '1;

   // Run of free blocks ending at each bit of the current word. Where the word is free
   // from bit 0 up to a position, the run carried in from earlier words continues.
   always_comb begin
      logic           zfound;
      logic [WI_W-1:0] zpos;
      for (int i = 0; i < WORD_W; i++) begin
         zfound = 1'b0;
         zpos   = '0;
         for (int j = 0; j <= i; j++) begin
            if (!word[j]) begin
               zfound = 1'b1;
               zpos   = WI_W'(j);
            end
         end
         if (zfound) begin
            run[i] = RUN_W'(i) - RUN_W'(zpos);
         end else begin
            run[i] = RUN_W'(cnt_ff) + RUN_W'(i) + RUN_W'(1);
         end
         hit[i] = (run[i] >= RUN_W'(len_ff));
      end
   end

   // Lowest position where the run reaches the asked length.
   always_comb begin
      hit_idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = WI_W'(i);
         end
      end
   end

   assign hit_any   = |hit;
   assign hit_blk   = {addr_ff, hit_idx};
   assign found_blk = BLK_W'(SUM_W'(hit_blk) + SUM_W'(1) - SUM_W'(len_ff));

   // Bits of the current word that lie inside the run being marked.
   assign first_word = first_ff[BLK_W-1:WI_W];
   assign last_word  = last_ff[BLK_W-1:WI_W];
   assign lo_off     = (addr_ff == first_word) ? first_ff[WI_W-1:0] : '0;
   assign hi_off     = (addr_ff == last_word) ? last_ff[WI_W-1:0] : '1;

   always_comb begin
      for (int p = 0; p < WORD_W; p++) begin
         mark_mask[p] = (WI_W'(p) >= lo_off) && (WI_W'(p) <= hi_off);
      end
   end

   assign wr_data = (op_ff == REQ_FREE) ? (word | mark_mask) : (word & ~mark_mask);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_port.run_length == '0) begin
                  state_in = S_DONE;
               end else if (req_port.req_type == REQ_ALLOC) begin
                  if (SUM_W'(req_port.run_length) > SUM_W'(N_BLOCKS)) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (req_end > SUM_W'(N_BLOCKS)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SEEK;
               end
            end
         end
         S_SCAN: begin
            if (hit_any) begin
               state_in = S_SEEK;
            end else if (addr_ff == WA_W'(N_WORDS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_SEEK: begin
            state_in = S_MARK;
         end
         S_MARK: begin
            if (addr_ff == last_word) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath, memory control and output register loading.
   always_comb begin
      op_in         = op_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      case (state_ff)
         S_IDLE: begin
            // Word 0 is read at acceptance so that the scan starts on the next cycle.
            if (req_accept) begin
               op_in    = req_port.req_type;
               len_in   = req_port.run_length;
               cnt_in   = '0;
               addr_in  = '0;
               found_in = '0;
               first_in = BLK_W'(req_port.start_block);
               last_in  = BLK_W'(req_end - SUM_W'(1));
               if (req_port.run_length == '0) begin
                  status_in = STAT_BAD_LEN;
               end else if (req_port.req_type == REQ_ALLOC) begin
                  if (SUM_W'(req_port.run_length) > SUM_W'(N_BLOCKS)) begin
                     status_in = STAT_NO_RUN;
                  end else begin
                     status_in = STAT_OK;
                  end
               end else if (req_end > SUM_W'(N_BLOCKS)) begin
                  status_in = STAT_PAST_END;
               end else begin
                  status_in = STAT_OK;
               end
            end
         end
         S_SCAN: begin
            rd_addr = WA_W'(addr_ff + 1'b1);
            if (hit_any) begin
               first_in = found_blk;
               last_in  = hit_blk;
               found_in = OUT_W'(found_blk);
            end else begin
               cnt_in  = run[WORD_W-1][LEN_W-1:0];
               addr_in = WA_W'(addr_ff + 1'b1);
               if (addr_ff == WA_W'(N_WORDS - 1)) begin
                  status_in = STAT_NO_RUN;
               end
            end
         end
         S_SEEK: begin
            rd_addr = first_word;
            addr_in = first_word;
         end
         S_MARK: begin
            // Write back this word while the next one is read; the addresses always differ.
            wr_en   = 1'b1;
            rd_addr = WA_W'(addr_ff + 1'b1);
            addr_in = WA_W'(addr_ff + 1'b1);
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_start_in  = found_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      addr_ff       <= addr_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   // Written-since-reset flags, one per map word.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[addr_ff] <= 1'b1;
      end
   end

   // Map memory with a registered read. A request always starts after the previous
   // item's last write has landed, so reads never see a stale word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_mem[addr_ff] <= wr_data;
      end
      rd_data_ff  <= free_mem[rd_addr];
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   // The carried run never reaches the asked length while the scan goes on.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cnt_ff < len_ff))
      else $error("scan carried a run that already fits");

   // Write-backs stay within the words covered by the run.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((addr_ff >= first_word) && (addr_ff <= last_word)))
      else $error("map write outside the marked run");

   // Only a successful request may report a nonzero start.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK)) |-> (rsp_start_ff == '0))
      else $error("failed request reports a run start");

endmodule
